@@ hdl/mlp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlp_pkg
// shared types, widths and arithmetic helpers for the perceptron trainer
// ----------------------------------------------------------------------------
package mlp_pkg;

   localparam int NUM_INPUTS = 7;
   localparam int IN_IW      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int KIND_W     = 2;
   localparam int FEAT_W     = 21;
   localparam int PARAM_W    = 32;
   localparam int SCORE_W    = 17;
   localparam int TGT_W      = 17;
   localparam int LR_W       = 21;
   localparam int IDX_W      = 6;
   localparam int ACC_W      = 60;
   localparam int Z_W        = ACC_W - 16;
   localparam int MA_W       = 33;
   localparam int MB_W       = 22;
   localparam int PROD_W     = MA_W + MB_W;
   localparam int SH_W       = PROD_W - 16;
   localparam int G_W        = 35;
   localparam int DOUT_W     = 18;
   localparam int ADDR_W     = 8;
   localparam int SEL_W      = 4;

   localparam logic [LR_W-1:0]    LR_RESET = 21'd327680;
   localparam logic [SCORE_W-1:0] ONE_Q    = 17'd65536;
   localparam logic [SCORE_W-1:0] HALF_Q   = 17'd32768;

   typedef enum logic [KIND_W-1:0] {
      KIND_PREDICT = 2'd0,
      KIND_TRAIN   = 2'd1,
      KIND_WRITE   = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LD_BIAS,
      OP_MAC_X,
      OP_SIG_H,
      OP_MAC_H,
      OP_SIG_Y,
      OP_SD_Y,
      OP_DOUT,
      OP_T1,
      OP_SD_H,
      OP_DHID,
      OP_G_HID,
      OP_G_OUT,
      OP_UPD_LO,
      OP_UPD_HI,
      OP_UPD_BIAS
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_F_BIAS,
      S_F_MAC,
      S_F_SIG,
      S_O_BIAS,
      S_O_MAC,
      S_O_SIG,
      S_B_SDY,
      S_B_DOUT,
      S_H_SDH,
      S_H_T1,
      S_H_DHID,
      S_H_G,
      S_H_UPD,
      S_H_BUPD,
      S_O_G,
      S_O_UPD,
      S_O_BUPD,
      S_DRAIN
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [SEL_W-1:0]    sel;
      logic                use_h;
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    load;
      logic    wr_item;
   } cmd_type;

   // piecewise-linear sigmoid on a signed Q28.16 value
   function automatic logic [SCORE_W-1:0] sig_q(input logic signed [Z_W-1:0] z);
      logic [Z_W-1:0]     a;
      logic [SCORE_W-1:0] y;
      a = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
      if (a >= Z_W'(327680))
         y = ONE_Q;
      else if (a >= Z_W'(155648))
         y = SCORE_W'(a >> 5) + SCORE_W'(55296);
      else if (a >= Z_W'(65536))
         y = SCORE_W'(a >> 3) + SCORE_W'(40960);
      else
         y = SCORE_W'(a >> 2) + SCORE_W'(32768);
      return z[Z_W-1] ? (ONE_Q - y) : y;
   endfunction

   // add with clamp to the signed 32-bit range
   function automatic logic [PARAM_W-1:0] sat_add(input logic signed [PARAM_W-1:0] old,
                                                  input logic signed [ACC_W-1:0] step);
      logic signed [ACC_W:0] s;
      logic [PARAM_W-1:0]    r;
      s = (ACC_W+1)'(old) + (ACC_W+1)'(step);
      if (s[ACC_W:PARAM_W-1] == '0 || s[ACC_W:PARAM_W-1] == '1)
         r = s[PARAM_W-1:0];
      else if (s[ACC_W])
         r = {1'b1, {(PARAM_W-1){1'b0}}};
      else
         r = {1'b0, {(PARAM_W-1){1'b1}}};
      return r;
   endfunction

endpackage

@@ hdl/mlp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlp_ctrl
// sequencer issuing at most one datapath operation per cycle for forward and update
// ----------------------------------------------------------------------------
module mlp_ctrl
   import mlp_pkg::*;
#(
   parameter int NUM_HIDDEN = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KIND_W-1:0]   req_kind,
   output logic                busy,
   output cmd_type             cmd
);

   localparam int HW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
   localparam int NW = NUM_HIDDEN * NUM_INPUTS;

   state_type       state_ff, state_in;
   logic [IN_IW-1:0] i_ff, i_in;
   logic [HW-1:0]   j_ff, j_in;
   logic            ph_ff, ph_in;
   logic            train_ff, train_in;
   logic            accept;
   logic            i_last, j_last;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign i_last = (i_ff == IN_IW'(NUM_INPUTS - 1));
   assign j_last = (j_ff == HW'(NUM_HIDDEN - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         ph_ff    <= 1'b0;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         ph_ff    <= ph_in;
         train_ff <= train_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      ph_in    = ph_ff;
      train_in = train_ff;
      case (state_ff)
         S_IDLE: begin
            i_in  = '0;
            j_in  = '0;
            ph_in = 1'b0;
            if (accept && (req_kind == KIND_PREDICT || req_kind == KIND_TRAIN)) begin
               train_in = (req_kind == KIND_TRAIN);
               state_in = S_F_BIAS;
            end
         end
         S_F_BIAS: begin
            i_in     = '0;
            state_in = S_F_MAC;
         end
         S_F_MAC: begin
            if (i_last) state_in = S_F_SIG;
            else        i_in = i_ff + 1'b1;
         end
         S_F_SIG: begin
            if (j_last) begin
               j_in     = '0;
               state_in = S_O_BIAS;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_F_BIAS;
            end
         end
         S_O_BIAS: state_in = S_O_MAC;
         S_O_MAC: begin
            if (j_last) begin
               j_in     = '0;
               state_in = S_O_SIG;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_O_SIG: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = train_ff ? S_B_SDY : S_DRAIN;
         end
         S_B_SDY: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_B_DOUT;
         end
         S_B_DOUT: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_H_SDH;
         end
         S_H_SDH: state_in = S_H_T1;
         S_H_T1: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_H_DHID;
         end
         S_H_DHID: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_H_G;
         end
         S_H_G: begin
            ph_in = !ph_ff;
            i_in  = '0;
            if (ph_ff) state_in = S_H_UPD;
         end
         S_H_UPD: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (i_last) state_in = S_H_BUPD;
               else        i_in = i_ff + 1'b1;
            end
         end
         S_H_BUPD: begin
            if (j_last) begin
               j_in     = '0;
               state_in = S_O_G;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_H_SDH;
            end
         end
         S_O_G: begin
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_O_UPD;
         end
         S_O_UPD: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (j_last) state_in = S_O_BUPD;
               else        j_in = j_ff + 1'b1;
            end
         end
         S_O_BUPD: state_in = S_DRAIN;
         S_DRAIN: begin
            // let the last write-back leave the pipeline
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd           = '0;
      cmd.uop.op    = OP_NOP;
      cmd.load      = accept;
      cmd.wr_item   = accept && (req_kind == KIND_WRITE);
      case (state_ff)
         S_F_BIAS: begin
            cmd.uop.op   = OP_LD_BIAS;
            cmd.uop.addr = ADDR_W'(NW) + ADDR_W'(j_ff);
         end
         S_F_MAC: begin
            cmd.uop.op   = OP_MAC_X;
            cmd.uop.addr = ADDR_W'(j_ff) * ADDR_W'(NUM_INPUTS) + ADDR_W'(i_ff);
            cmd.uop.sel  = SEL_W'(i_ff);
         end
         S_F_SIG: begin
            cmd.uop.op  = OP_SIG_H;
            cmd.uop.sel = SEL_W'(j_ff);
         end
         S_O_BIAS: begin
            cmd.uop.op   = OP_LD_BIAS;
            cmd.uop.addr = ADDR_W'(NW + 2 * NUM_HIDDEN);
         end
         S_O_MAC: begin
            cmd.uop.op   = OP_MAC_H;
            cmd.uop.addr = ADDR_W'(NW + NUM_HIDDEN) + ADDR_W'(j_ff);
            cmd.uop.sel  = SEL_W'(j_ff);
         end
         S_O_SIG:  if (!ph_ff) cmd.uop.op = OP_SIG_Y;
         S_B_SDY:  if (!ph_ff) cmd.uop.op = OP_SD_Y;
         S_B_DOUT: if (!ph_ff) cmd.uop.op = OP_DOUT;
         S_H_SDH: begin
            cmd.uop.op  = OP_SD_H;
            cmd.uop.sel = SEL_W'(j_ff);
         end
         S_H_T1: begin
            if (!ph_ff) begin
               cmd.uop.op   = OP_T1;
               cmd.uop.addr = ADDR_W'(NW + NUM_HIDDEN) + ADDR_W'(j_ff);
            end
         end
         S_H_DHID: if (!ph_ff) cmd.uop.op = OP_DHID;
         S_H_G:    if (!ph_ff) cmd.uop.op = OP_G_HID;
         S_H_UPD: begin
            cmd.uop.op   = ph_ff ? OP_UPD_HI : OP_UPD_LO;
            cmd.uop.addr = ADDR_W'(j_ff) * ADDR_W'(NUM_INPUTS) + ADDR_W'(i_ff);
            cmd.uop.sel  = SEL_W'(i_ff);
         end
         S_H_BUPD: begin
            cmd.uop.op   = OP_UPD_BIAS;
            cmd.uop.addr = ADDR_W'(NW) + ADDR_W'(j_ff);
         end
         S_O_G: if (!ph_ff) cmd.uop.op = OP_G_OUT;
         S_O_UPD: begin
            cmd.uop.op    = ph_ff ? OP_UPD_HI : OP_UPD_LO;
            cmd.uop.addr  = ADDR_W'(NW + NUM_HIDDEN) + ADDR_W'(j_ff);
            cmd.uop.sel   = SEL_W'(j_ff);
            cmd.uop.use_h = 1'b1;
         end
         S_O_BUPD: begin
            cmd.uop.op   = OP_UPD_BIAS;
            cmd.uop.addr = ADDR_W'(NW + 2 * NUM_HIDDEN);
         end
         default: cmd.uop.op = OP_NOP;
      endcase
   end

endmodule

@@ hdl/mlp_dp.sv @@
// ----------------------------------------------------------------------------
// mlp_dp
// parameter memory, shared multiplier, accumulator and update write-back
// ----------------------------------------------------------------------------
module mlp_dp
   import mlp_pkg::*;
#(
   parameter int NUM_HIDDEN = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmd_type                               cmd,
   input  logic [NUM_INPUTS-1:0][FEAT_W-1:0]     req_features,
   input  logic [TGT_W-1:0]                      req_target,
   input  logic [IDX_W-1:0]                      req_param_index,
   input  logic [PARAM_W-1:0]                    req_param_value,
   input  logic                                  csr_wr_en,
   input  logic [LR_W-1:0]                       csr_wr_data,
   output logic                                  rsp_valid,
   output logic [SCORE_W-1:0]                    rsp_score,
   output logic                                  rsp_is_positive
);

   localparam int NP = NUM_HIDDEN * NUM_INPUTS + 2 * NUM_HIDDEN + 1;
   localparam int AW = $clog2(NP);
   localparam int HW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

   logic [PARAM_W-1:0]          mem [NP];
   logic [NP-1:0]               vld_ff;
   logic [PARAM_W-1:0]          rd_ff;
   logic                        rdv_ff;
   logic signed [PARAM_W-1:0]   rdval;
   logic signed [PARAM_W-1:0]   rd2_ff;

   logic [LR_W-1:0]             lr_ff;
   logic signed [FEAT_W-1:0]    x_ff [NUM_INPUTS];
   logic [TGT_W-1:0]            tgt_ff;
   logic [SCORE_W-1:0]          h_ff [NUM_HIDDEN];
   logic [SCORE_W-1:0]          y_ff;
   logic [SCORE_W-1:0]          u_ff;
   logic signed [DOUT_W-1:0]    dout_ff;
   logic signed [MA_W-1:0]      t_ff;
   logic signed [G_W-1:0]       g_ff;
   logic signed [SH_W-1:0]      plo_ff;
   logic signed [ACC_W-1:0]     acc_ff;

   uop_type                     op1_ff, op2_ff;
   logic signed [MA_W-1:0]      a_op;
   logic signed [MB_W-1:0]      b_op;
   logic signed [MB_W-1:0]      m_op;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [SH_W-1:0]      prod_sh;
   logic signed [Z_W-1:0]       z;
   logic [SCORE_W-1:0]          sig_val;
   logic signed [ACC_W-1:0]     step;

   logic                        mem_we;
   logic [AW-1:0]               mem_wa;
   logic [PARAM_W-1:0]          mem_wd;

   logic                        rsp_valid_ff;
   logic [SCORE_W-1:0]          rsp_score_ff;
   logic                        rsp_pos_ff;

   // memory with per-entry valid bits so unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff  <= mem[cmd.uop.addr[AW-1:0]];
      rdv_ff <= vld_ff[cmd.uop.addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset)       vld_ff <= '0;
      else if (mem_we) vld_ff[mem_wa] <= 1'b1;
   end

   assign rdval = rdv_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset)          lr_ff <= LR_RESET;
      else if (csr_wr_en) lr_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < NUM_INPUTS; k++) x_ff[k] <= req_features[k];
         tgt_ff <= req_target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op1_ff <= '0;
         op2_ff <= '0;
      end else begin
         op1_ff <= cmd.uop;
         op2_ff <= op1_ff;
      end
   end

   // stage 1: operand select and multiply
   always_comb begin
      m_op = op1_ff.use_h ? MB_W'({1'b0, h_ff[op1_ff.sel[HW-1:0]]})
                          : MB_W'(x_ff[op1_ff.sel[IN_IW-1:0]]);
      a_op = '0;
      b_op = '0;
      case (op1_ff.op)
         OP_MAC_X: begin
            a_op = MA_W'(rdval);
            b_op = MB_W'(x_ff[op1_ff.sel[IN_IW-1:0]]);
         end
         OP_MAC_H: begin
            a_op = MA_W'(rdval);
            b_op = MB_W'({1'b0, h_ff[op1_ff.sel[HW-1:0]]});
         end
         OP_SD_Y: begin
            a_op = MA_W'({1'b0, y_ff});
            b_op = MB_W'({1'b0, ONE_Q}) - MB_W'({1'b0, y_ff});
         end
         OP_SD_H: begin
            a_op = MA_W'({1'b0, h_ff[op1_ff.sel[HW-1:0]]});
            b_op = MB_W'({1'b0, ONE_Q}) - MB_W'({1'b0, h_ff[op1_ff.sel[HW-1:0]]});
         end
         OP_DOUT: begin
            a_op = MA_W'({1'b0, tgt_ff}) - MA_W'({1'b0, y_ff});
            b_op = MB_W'({1'b0, u_ff});
         end
         OP_T1: begin
            a_op = MA_W'(rdval);
            b_op = MB_W'(dout_ff);
         end
         OP_DHID: begin
            a_op = t_ff;
            b_op = MB_W'({1'b0, u_ff});
         end
         OP_G_HID: begin
            a_op = t_ff;
            b_op = MB_W'({1'b0, lr_ff});
         end
         OP_G_OUT: begin
            a_op = MA_W'(dout_ff);
            b_op = MB_W'({1'b0, lr_ff});
         end
         // step split: g*m = (g>>16)*m*2^16 + g[15:0]*m
         OP_UPD_LO: begin
            a_op = MA_W'({1'b0, g_ff[15:0]});
            b_op = m_op;
         end
         OP_UPD_HI: begin
            a_op = MA_W'(g_ff >>> 16);
            b_op = m_op;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
      rd2_ff  <= rdval;
   end

   // stage 2: accumulate, activate, write back
   assign prod_sh = prod_ff[PROD_W-1:16];
   assign z       = acc_ff[ACC_W-1:16];
   assign sig_val = sig_q(z);

   always_ff @(posedge clock) begin
      case (op2_ff.op)
         OP_LD_BIAS: acc_ff <= {{(ACC_W-PARAM_W-16){rd2_ff[PARAM_W-1]}}, rd2_ff, 16'b0};
         OP_MAC_X,
         OP_MAC_H:   acc_ff <= acc_ff + ACC_W'(prod_ff);
         OP_SIG_H:   h_ff[op2_ff.sel[HW-1:0]] <= sig_val;
         OP_SIG_Y:   y_ff <= sig_val;
         OP_SD_Y,
         OP_SD_H:    u_ff <= SCORE_W'(prod_sh);
         OP_DOUT:    dout_ff <= DOUT_W'(prod_sh);
         OP_T1,
         OP_DHID:    t_ff <= MA_W'(prod_sh);
         OP_G_HID,
         OP_G_OUT:   g_ff <= G_W'(prod_sh);
         OP_UPD_LO:  plo_ff <= prod_sh;
         default:    acc_ff <= acc_ff;
      endcase
   end

   assign step = (op2_ff.op == OP_UPD_HI) ? (ACC_W'(prod_ff) + ACC_W'(plo_ff))
                                          : ACC_W'(g_ff);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      if (cmd.wr_item) begin
         mem_we = (32'(req_param_index) < 32'(NP));
         mem_wa = AW'(req_param_index);
         mem_wd = req_param_value;
      end else if (op2_ff.op == OP_UPD_HI || op2_ff.op == OP_UPD_BIAS) begin
         mem_we = 1'b1;
         mem_wa = op2_ff.addr[AW-1:0];
         mem_wd = sat_add(rd2_ff, step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= (op2_ff.op == OP_SIG_Y);
   end

   always_ff @(posedge clock) begin
      if (op2_ff.op == OP_SIG_Y) begin
         rsp_score_ff <= sig_val;
         rsp_pos_ff   <= (sig_val > HALF_Q);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score       = rsp_score_ff;
   assign rsp_is_positive = rsp_pos_ff;

endmodule

@@ hdl/mlp_7_4_1_online_backprop.sv @@
// ----------------------------------------------------------------------------
// mlp_7_4_1_online_backprop
// two-layer sigmoid perceptron with online backprop training
//
//   channel   ports                          handshake
//   request   req_kind .. req_param_value    start, accepted when !busy
//   result    rsp_score, rsp_is_positive     rsp_valid, one-cycle strobe
//   config    csr_wr_data                    csr_wr_en, written same edge
//
// predict runs the hidden layer and then the output neuron; train then adds
// the backward pass and the hidden and output weight updates.
// write and unused items are handled in the accept cycle and do not raise busy.
// the work runs on one shared multiplier fed from a parameter memory with one
// read and one write port, at most one operation issued per cycle through a three-stage pipe.
// synchronous reset clears the sequencer and valid bits and sets the learning rate to LR_RESET.
// rsp_valid is not held: the receiver takes rsp_* in the strobe cycle.
// ----------------------------------------------------------------------------
module mlp_7_4_1_online_backprop
   import mlp_pkg::*;
#(
   parameter int NUM_HIDDEN = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [FEAT_W-1:0]   req_feature_0,
   input  logic [FEAT_W-1:0]   req_feature_1,
   input  logic [FEAT_W-1:0]   req_feature_2,
   input  logic [FEAT_W-1:0]   req_feature_3,
   input  logic [FEAT_W-1:0]   req_feature_4,
   input  logic [FEAT_W-1:0]   req_feature_5,
   input  logic [FEAT_W-1:0]   req_feature_6,
   input  logic [TGT_W-1:0]    req_target,
   input  logic [IDX_W-1:0]    req_param_index,
   input  logic [PARAM_W-1:0]  req_param_value,
   input  logic                csr_wr_en,
   input  logic [LR_W-1:0]     csr_wr_data,
   output logic                rsp_valid,
   output logic [SCORE_W-1:0]  rsp_score,
   output logic                rsp_is_positive
);

   cmd_type                           cmd;
   logic [NUM_INPUTS-1:0][FEAT_W-1:0] features;

   assign features = {req_feature_6, req_feature_5, req_feature_4, req_feature_3,
                      req_feature_2, req_feature_1, req_feature_0};

   mlp_ctrl #(
      .NUM_HIDDEN (NUM_HIDDEN)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd)
   );

   mlp_dp #(
      .NUM_HIDDEN (NUM_HIDDEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_features    (features),
      .req_target      (req_target),
      .req_param_index (req_param_index),
      .req_param_value (req_param_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_score       (rsp_score),
      .rsp_is_positive (rsp_is_positive)
   );

endmodule

@@ hdl/mlp_chk.sv @@
// ----------------------------------------------------------------------------
// mlp_chk
// port-level checks on the perceptron trainer, bound to the top level
// ----------------------------------------------------------------------------
module mlp_chk
   import mlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic                rsp_valid,
   input  logic [SCORE_W-1:0]  rsp_score,
   input  logic                rsp_is_positive
);

   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> (!busy && !rsp_valid))
      else $error("not idle after reset");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_PREDICT || req_kind == KIND_TRAIN)) |=> busy)
      else $error("compute item did not raise busy");

   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_WRITE || req_kind == KIND_NONE)) |=> !busy)
      else $error("write item held the block busy");

   a_rsp_in_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in work");

   a_rsp_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_score <= ONE_Q && rsp_is_positive == (rsp_score > HALF_Q)))
      else $error("inconsistent result");

endmodule

bind mlp_7_4_1_online_backprop mlp_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_kind        (req_kind),
   .rsp_valid       (rsp_valid),
   .rsp_score       (rsp_score),
   .rsp_is_positive (rsp_is_positive)
);
